>>> sv/bppg_pkg.sv
`default_nettype none

package bppg_pkg;

  // Field and register widths
  localparam int PeriodW = 24;
  localparam int PulseW  = 24;
  localparam int GapW    = 16;
  localparam int CfgW    = 24;
  localparam int CfgIdxW = 2;

  // Down-counter width default
  localparam int CountBitsDef = 24;

  // Register reset values
  localparam logic [PeriodW-1:0] PeriodRst = PeriodW'(10000);
  localparam logic [PulseW-1:0]  PulseRst  = PulseW'(100);
  localparam logic [GapW-1:0]    GapRst    = GapW'(20);

  // Register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_PERIOD = 2'd0,
    REG_PULSE  = 2'd1,
    REG_GAP    = 2'd2
  } reg_idx_e;

  // Result beat layout, highest bit first
  typedef struct packed {
    logic [3:0] pad;
    logic       pulse_fitted;
    logic       period_start;
    logic       second_level;
    logic       first_level;
  } result_t;

endpackage

`default_nettype wire

>>> sv/biphasic_pulse_pair_generator.sv
`default_nettype none

// Result register: a tick beat accepted at a clock edge shows its result beat in the next cycle.
// Throughput: one tick beat per cycle; s_axis_tready drops only while a result
//   beat is held and m_axis_tready is low (the result register is the only stage).
// Reset: rst_ni (async, active low) clears the phase, counter and output valid,
//   and loads period 10000, pulse 100, gap 20 ticks.
module biphasic_pulse_pair_generator #(
  parameter int COUNT_BITS = bppg_pkg::CountBitsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // tick stream
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [7:0]                   s_axis_tdata,  // [0] run, [7:1] zero
  // result stream
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [7:0]                        m_axis_tdata,  // [0] first_level,
                                                           // [1] second_level,
                                                           // [2] period_start,
                                                           // [3] pulse_fitted
  // configuration writes
  input  wire logic                         cfg_we_i,
  input  wire logic [bppg_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [bppg_pkg::CfgW-1:0]    cfg_data_i
);

  localparam int LenW = (COUNT_BITS > bppg_pkg::PeriodW) ? COUNT_BITS : bppg_pkg::PeriodW;
  localparam logic [COUNT_BITS-1:0] CntMax = '1;
  localparam int SumW = bppg_pkg::PulseW + 2;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_FIRST  = 3'd1,
    PH_GAP    = 3'd2,
    PH_SECOND = 3'd3,
    PH_REST   = 3'd4
  } phase_e;

  // Phase length load: zero lasts one tick, long lengths saturate
  function automatic logic [COUNT_BITS-1:0] load_len(input logic [bppg_pkg::PeriodW-1:0] len);
    logic [LenW-1:0]       len_x;
    logic [COUNT_BITS-1:0] res;
    len_x = LenW'(len);
    if (len == '0) begin
      res = COUNT_BITS'(1);
    end else if (len_x > LenW'(CntMax)) begin
      res = CntMax;
    end else begin
      res = COUNT_BITS'(len_x);
    end
    return res;
  endfunction

  logic [bppg_pkg::PeriodW-1:0] period_q;
  logic [bppg_pkg::PulseW-1:0]  pulse_q;
  logic [bppg_pkg::GapW-1:0]    gap_q;

  phase_e                       phase_q, phase_d;
  logic [COUNT_BITS-1:0]        remaining_q, remaining_d;
  logic [bppg_pkg::PulseW-1:0]  fitted_q, fitted_d;

  logic                         out_valid_q;
  bppg_pkg::result_t            out_data_q, out_data_d;

  logic                         accept;
  logic                         run;

  // Fit check and fitted pulse from the live registers
  logic [SumW-1:0]              need_sum;
  logic                         needs_fit;
  logic [bppg_pkg::PeriodW-1:0] period_less_gap;
  logic [bppg_pkg::PulseW-1:0]  fit_pulse;

  // Rest length from the latched pulse
  logic [SumW-1:0]              used;
  logic [SumW-1:0]              rest_diff;
  logic [bppg_pkg::PeriodW-1:0] rest_len;

  // Effective phase and count for this tick
  phase_e                       ph;
  logic [COUNT_BITS-1:0]        rem;
  logic                         start;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign run           = s_axis_tdata[0];

  assign need_sum        = {1'b0, pulse_q, 1'b0} + SumW'(gap_q);
  assign needs_fit       = need_sum >= SumW'(period_q);
  assign period_less_gap = period_q - bppg_pkg::PeriodW'(gap_q);

  always_comb begin
    if (!needs_fit) begin
      fit_pulse = pulse_q;
    end else if (period_q > bppg_pkg::PeriodW'(gap_q)) begin
      fit_pulse = bppg_pkg::PulseW'(period_less_gap >> 1);
    end else begin
      fit_pulse = '0;
    end
  end

  assign used      = {1'b0, fitted_q, 1'b0} + SumW'(gap_q);
  assign rest_diff = SumW'(period_q) - used;
  assign rest_len  = (used < SumW'(period_q)) ? rest_diff[bppg_pkg::PeriodW-1:0] : '0;

  // Next state and result for one tick
  always_comb begin
    fitted_d   = fitted_q;
    ph         = phase_q;
    rem        = remaining_q;
    start      = 1'b0;
    phase_d    = PH_IDLE;
    remaining_d = '0;
    out_data_d = '0;
    out_data_d.pulse_fitted = needs_fit;

    if (run) begin
      if (phase_q != PH_FIRST && phase_q != PH_GAP &&
          phase_q != PH_SECOND && phase_q != PH_REST) begin
        fitted_d = fit_pulse;
        ph       = PH_FIRST;
        rem      = load_len(fit_pulse);
        start    = 1'b1;
      end
      out_data_d.first_level  = (ph == PH_FIRST);
      out_data_d.second_level = (ph == PH_SECOND);
      out_data_d.period_start = start;

      if (rem <= COUNT_BITS'(1)) begin
        case (ph)
          PH_FIRST: begin
            phase_d     = PH_GAP;
            remaining_d = load_len(bppg_pkg::PeriodW'(gap_q));
          end
          PH_GAP: begin
            phase_d     = PH_SECOND;
            remaining_d = load_len(fitted_q);
          end
          PH_SECOND: begin
            phase_d     = PH_REST;
            remaining_d = load_len(rest_len);
          end
          default: begin
            phase_d     = PH_IDLE;
            remaining_d = '0;
          end
        endcase
      end else begin
        phase_d     = ph;
        remaining_d = rem - COUNT_BITS'(1);
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= bppg_pkg::PeriodRst;
      pulse_q  <= bppg_pkg::PulseRst;
      gap_q    <= bppg_pkg::GapRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bppg_pkg::REG_PERIOD: period_q <= cfg_data_i[bppg_pkg::PeriodW-1:0];
        bppg_pkg::REG_PULSE:  pulse_q  <= cfg_data_i[bppg_pkg::PulseW-1:0];
        bppg_pkg::REG_GAP:    gap_q    <= cfg_data_i[bppg_pkg::GapW-1:0];
        default: ;
      endcase
    end
  end

  // Phase state, advanced once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      remaining_q <= '0;
      fitted_q    <= '0;
    end else if (accept) begin
      phase_q     <= phase_d;
      remaining_q <= remaining_d;
      fitted_q    <= fitted_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

`default_nettype wire

>>> test/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 200000;
  localparam longint unsigned CountMax = (64'd1 << bppg_pkg::CountBitsDef) - 64'd1;

  // Waveform phases of the predictor
  typedef enum logic [2:0] {
    WAVE_IDLE   = 3'd0,
    WAVE_FIRST  = 3'd1,
    WAVE_GAP    = 3'd2,
    WAVE_SECOND = 3'd3,
    WAVE_REST   = 3'd4
  } wave_phase_e;

  // Predicts the output levels of each tick and checks the result beats
  class pulse_pair_tracker;
    logic [bppg_pkg::PeriodW-1:0] period_reg;
    logic [bppg_pkg::PulseW-1:0]  pulse_reg;
    logic [bppg_pkg::GapW-1:0]    gap_reg;
    wave_phase_e                  phase;
    longint unsigned              remaining;
    longint unsigned              fitted;
    bppg_pkg::result_t            levels_due[$];
    int                           errors;

    function new();
      period_reg = bppg_pkg::PeriodRst;
      pulse_reg  = bppg_pkg::PulseRst;
      gap_reg    = bppg_pkg::GapRst;
      phase      = WAVE_IDLE;
      remaining  = 0;
      fitted     = 0;
      errors     = 0;
    endfunction

    function void set_reg(bppg_pkg::reg_idx_e idx, logic [bppg_pkg::CfgW-1:0] value);
      case (idx)
        bppg_pkg::REG_PERIOD: period_reg = value[bppg_pkg::PeriodW-1:0];
        bppg_pkg::REG_PULSE:  pulse_reg  = value[bppg_pkg::PulseW-1:0];
        bppg_pkg::REG_GAP:    gap_reg    = value[bppg_pkg::GapW-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return levels_due.size();
    endfunction

    // Two pulses plus gap do not leave room in the period
    function bit over_budget();
      longint unsigned p, g, per;
      p = 64'(pulse_reg);
      g = 64'(gap_reg);
      per = 64'(period_reg);
      return (2 * p + g) >= per;
    endfunction

    // Zero-length phases last one tick; long ones saturate
    function longint unsigned clamp_len(longint unsigned len);
      if (len == 0) return 1;
      if (len > CountMax) return CountMax;
      return len;
    endfunction

    function void note_tick(bit run);
      bppg_pkg::result_t r;
      longint unsigned   used, per, g;
      r   = '0;
      per = 64'(period_reg);
      g   = 64'(gap_reg);
      if (!run) begin
        phase     = WAVE_IDLE;
        remaining = 0;
      end else begin
        // new period: latch the pulse length, cut to fit if needed
        if (phase == WAVE_IDLE) begin
          if (!over_budget()) fitted = 64'(pulse_reg);
          else if (per > g) fitted = (per - g) / 2;
          else fitted = 0;
          fitted         = fitted & 64'hFF_FFFF;
          phase          = WAVE_FIRST;
          remaining      = clamp_len(fitted);
          r.period_start = 1'b1;
        end
        r.first_level  = (phase == WAVE_FIRST);
        r.second_level = (phase == WAVE_SECOND);
        if (remaining > 1) begin
          remaining = remaining - 1;
        end else begin
          case (phase)
            WAVE_FIRST: begin
              phase     = WAVE_GAP;
              remaining = clamp_len(g);
            end
            WAVE_GAP: begin
              phase     = WAVE_SECOND;
              remaining = clamp_len(fitted);
            end
            WAVE_SECOND: begin
              used      = 2 * fitted + g;
              phase     = WAVE_REST;
              remaining = clamp_len(used < per ? per - used : 0);
            end
            default: begin
              phase     = WAVE_IDLE;
              remaining = 0;
            end
          endcase
        end
      end
      r.pulse_fitted = over_budget();
      levels_due.push_back(r);
    endfunction

    task report(string what);
      if (errors < 40) $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(bppg_pkg::result_t got);
      bppg_pkg::result_t want;
      if (levels_due.size() == 0) begin
        report("result beat with no tick waiting");
      end else begin
        want = levels_due.pop_front();
        if (got.first_level !== want.first_level)
          report($sformatf("first_level %b, expected %b", got.first_level, want.first_level));
        if (got.second_level !== want.second_level)
          report($sformatf("second_level %b, expected %b", got.second_level,
                           want.second_level));
        if (got.period_start !== want.period_start)
          report($sformatf("period_start %b, expected %b", got.period_start,
                           want.period_start));
        if (got.pulse_fitted !== want.pulse_fitted)
          report($sformatf("pulse_fitted %b, expected %b", got.pulse_fitted,
                           want.pulse_fitted));
      end
    endtask
  endclass

  logic                           clk_i;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [7:0]                     s_axis_tdata  = '0;  // [0] run, [7:1] zero
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [7:0]                     m_axis_tdata;        // [0] first_level, [1] second_level,
                                                       // [2] period_start, [3] pulse_fitted
  logic                           cfg_we_i      = 1'b0;
  logic [bppg_pkg::CfgIdxW-1:0]   cfg_idx_i     = '0;
  logic [bppg_pkg::CfgW-1:0]      cfg_data_i    = '0;

  int tx_idle_pct = 30;
  int rx_idle_pct = 30;
  int cycles      = 0;

  pulse_pair_tracker tracker = new();

  biphasic_pulse_pair_generator #(
    .COUNT_BITS(bppg_pkg::CountBitsDef)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Result side backpressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Beat monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        tracker.check_result(bppg_pkg::result_t'(m_axis_tdata));
      if (s_axis_tvalid && s_axis_tready) tracker.note_tick(s_axis_tdata[0]);
    end
  end

  // Run limit
  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // One tick beat, with random idle cycles ahead of it
  task automatic send_tick(bit run);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, run};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_ticks(bit run, int count);
    repeat (count) send_tick(run);
  endtask

  // Stop sending and let every result beat come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (tracker.pending() != 0);
    @(negedge clk_i);
  endtask

  task automatic apply_config(logic [bppg_pkg::CfgW-1:0] per, logic [bppg_pkg::CfgW-1:0] pul,
                              logic [bppg_pkg::CfgW-1:0] gp);
    bppg_pkg::reg_idx_e        idx[3];
    logic [bppg_pkg::CfgW-1:0] val[3];
    idx = '{bppg_pkg::REG_PERIOD, bppg_pkg::REG_PULSE, bppg_pkg::REG_GAP};
    val = '{per, pul, gp};
    for (int i = 0; i < 3; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= val[i];
      @(posedge clk_i);
      tracker.set_reg(idx[i], val[i]);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Random settings, then mostly long run bursts with short stops between
  task automatic random_phase(int ticks, bit quiet);
    logic [bppg_pkg::CfgW-1:0] per, pul, gp;
    int left, n;
    wait_drained();
    tx_idle_pct = quiet ? 0 : 30;
    rx_idle_pct = quiet ? 0 : 30;
    case ($urandom_range(9))
      0: begin
        per = bppg_pkg::CfgW'($urandom_range(2, 24'hFF_FFFF));
        pul = bppg_pkg::CfgW'($urandom);
        gp  = bppg_pkg::CfgW'($urandom);
      end
      1, 2: begin
        per = bppg_pkg::CfgW'($urandom_range(2, 6));
        pul = bppg_pkg::CfgW'($urandom_range(0, 4));
        gp  = bppg_pkg::CfgW'($urandom_range(0, 4));
      end
      default: begin
        per = bppg_pkg::CfgW'($urandom_range(2, 48));
        pul = bppg_pkg::CfgW'($urandom_range(0, per));
        gp  = bppg_pkg::CfgW'($urandom_range(0, per));
      end
    endcase
    // upper bits of the gap write are ignored by the block
    gp[bppg_pkg::CfgW-1:bppg_pkg::GapW] = (bppg_pkg::CfgW-bppg_pkg::GapW)'($urandom);
    apply_config(per, pul, gp);
    left = ticks;
    while (left > 0) begin
      n = $urandom_range(8, 60);
      if (n > left) n = left;
      send_ticks(1'b1, n);
      left -= n;
      if (left > 0 && $urandom_range(2) == 0) begin
        n = $urandom_range(1, 3);
        if (n > left) n = left;
        send_ticks(1'b0, n);
        left -= n;
      end
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings, with a stop in the middle of the first pulse
    send_ticks(1'b1, 3);
    send_tick(1'b0);
    send_tick(1'b1);
    // pulses and gap of zero length
    wait_drained();
    apply_config(24'd2, 24'd0, 24'd0);
    send_ticks(1'b1, 6);
    // gap longer than the period: pulse cut to zero
    wait_drained();
    apply_config(24'd3, 24'd1, 24'd5);
    send_ticks(1'b1, 5);
    // all registers at their maximum
    wait_drained();
    apply_config(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
    send_ticks(1'b1, 3);
    send_tick(1'b0);
    // pulses fill the period exactly, rest held to one tick
    wait_drained();
    apply_config(24'd8, 24'd3, 24'd2);
    send_ticks(1'b1, 4);

    for (int p = 0; p < 10; p++) random_phase((p == 3) ? 200 : 70, p == 3);

    wait_drained();
    repeat (4) @(negedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
sv/bppg_pkg.sv
sv/biphasic_pulse_pair_generator.sv
test/testbench.sv
